FILE: rtl/bdag_pkg.sv
// ----------------------------------------------------------------------------
// bdag_pkg
// Shared constants, register map, reciprocal table and glyph ladder for the
// box downscaler with glyph output.
// ----------------------------------------------------------------------------
package bdag_pkg;

	// default sizes of the line store and the block
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_BLOCK_DEF = 16;

	// fixed field and register widths
	localparam int ROW_LIMIT = 1024;
	localparam int ROW_W     = 10;
	localparam int BLOCK_W   = 5;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 11;
	localparam int SUM_W     = 16;
	localparam int GREY_W    = 8;
	localparam int GLYPH_W   = 7;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	// register reset values
	localparam logic [BLOCK_W-1:0]  BLOCK_SIZE_RST   = 5'd1;
	localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

	// ceil(2^24 / (b*b)) for b = 1..16; exact quotient for any 16-bit sum
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 25;
	typedef logic [RECIP_W-1:0] recip_t;
	localparam recip_t RECIP [16] = '{
		25'd16777216, 25'd4194304, 25'd1864136, 25'd1048576,
		25'd671089,   25'd466034,  25'd342393,  25'd262144,
		25'd207127,   25'd167773,  25'd138655,  25'd116509,
		25'd99274,    25'd85599,   25'd74566,   25'd65536
	};

	// threshold ladder, brightest first
	localparam logic [GREY_W-1:0] THR_SPACE = 8'd226;
	localparam logic [GREY_W-1:0] THR_DOT   = 8'd198;
	localparam logic [GREY_W-1:0] THR_STAR  = 8'd170;
	localparam logic [GREY_W-1:0] THR_COLON = 8'd142;
	localparam logic [GREY_W-1:0] THR_O     = 8'd114;
	localparam logic [GREY_W-1:0] THR_AMP   = 8'd86;
	localparam logic [GREY_W-1:0] THR_EIGHT = 8'd58;
	localparam logic [GREY_W-1:0] THR_HASH  = 8'd30;

	localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
	localparam logic [GLYPH_W-1:0] GLYPH_DOT   = 7'd46;
	localparam logic [GLYPH_W-1:0] GLYPH_STAR  = 7'd42;
	localparam logic [GLYPH_W-1:0] GLYPH_COLON = 7'd58;
	localparam logic [GLYPH_W-1:0] GLYPH_O     = 7'd111;
	localparam logic [GLYPH_W-1:0] GLYPH_AMP   = 7'd38;
	localparam logic [GLYPH_W-1:0] GLYPH_EIGHT = 7'd56;
	localparam logic [GLYPH_W-1:0] GLYPH_HASH  = 7'd35;
	localparam logic [GLYPH_W-1:0] GLYPH_AT    = 7'd64;

	// map a mean grey level to its glyph
	function automatic logic [GLYPH_W-1:0] pick_glyph(input logic [GREY_W-1:0] g);
		logic [GLYPH_W-1:0] c;
		if (g > THR_SPACE)      c = GLYPH_SPACE;
		else if (g > THR_DOT)   c = GLYPH_DOT;
		else if (g > THR_STAR)  c = GLYPH_STAR;
		else if (g > THR_COLON) c = GLYPH_COLON;
		else if (g > THR_O)     c = GLYPH_O;
		else if (g > THR_AMP)   c = GLYPH_AMP;
		else if (g > THR_EIGHT) c = GLYPH_EIGHT;
		else if (g > THR_HASH)  c = GLYPH_HASH;
		else                    c = GLYPH_AT;
		return c;
	endfunction

endpackage

FILE: rtl/bdag_if.sv
// ----------------------------------------------------------------------------
// bdag stream interfaces
// Valid/ready channels for pixel words in and glyph words out.
// ----------------------------------------------------------------------------
interface bdag_pix_if;
	logic                         valid;
	logic                         ready;
	logic [bdag_pkg::GREY_W-1:0]  grey_level;

	modport source (output valid, output grey_level, input ready);
	modport sink   (input valid, input grey_level, output ready);
endinterface

interface bdag_glyph_if;
	logic                         valid;
	logic                         ready;
	logic [bdag_pkg::GREY_W-1:0]  mean_grey;
	logic [bdag_pkg::GLYPH_W-1:0] glyph_code;
	logic                         row_last;
	logic                         frame_last;

	modport source (output valid, output mean_grey, output glyph_code,
		output row_last, output frame_last, input ready);
	modport sink   (input valid, input mean_grey, input glyph_code,
		input row_last, input frame_last, output ready);
endinterface

FILE: rtl/box_downscale_ascii_glyph.sv
// ----------------------------------------------------------------------------
// box_downscale_ascii_glyph
// Box-filter downscaler: averages square blocks of grey pixels and maps each
// block mean to an ASCII glyph code.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : valid/ready sink, one 8-bit grey word per pixel, raster order.
//   glyph  : valid/ready source, one word per whole block (mean, glyph code,
//            end-of-row and end-of-frame flags). Partial edge blocks give none.
//   APB    : block_size at 0x0, image_width at 0x4, image_height at 0x8.
// Intake: a pixel that does not close a block column leaves pixel.ready
//   high; one that closes a block column holds it low while the line store
//   is read, then the sum is added and written back; one that closes a
//   whole block holds it low through read, add, reciprocal multiply and
//   glyph lookup into the output register, and while that register stalls.
//   The single-port line store of per-column partial sums causes them.
// Reset and configuration: after reset and after every register write the
//   block holds pixel.ready low while a bit-serial remainder unit finds the
//   whole-block spans.
// Stall: the output register holds a result while the receiver stalls; the
//   next pixels are still taken until another result is ready to load.
// ----------------------------------------------------------------------------
module box_downscale_ascii_glyph #(
	parameter int MAX_WIDTH = bdag_pkg::MAX_WIDTH_DEF,
	parameter int MAX_BLOCK = bdag_pkg::MAX_BLOCK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bdag_pix_if.sink                      pixel,
	bdag_glyph_if.source                  glyph,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdag_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdag_pkg::DATA_W-1:0]   pwdata,
	output logic [bdag_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CPW  = $clog2(MAX_WIDTH);
	localparam int CMPW = (CPW + 1 > bdag_pkg::WIDTH_W) ? CPW + 1 : bdag_pkg::WIDTH_W;
	localparam int BW   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CNTW = $clog2(CMPW + 1);
	localparam int RW   = bdag_pkg::ROW_W;
	localparam int SW   = bdag_pkg::SUM_W;
	localparam int GW   = bdag_pkg::GREY_W;
	localparam int KW   = bdag_pkg::BLOCK_W;

	localparam logic [CMPW-1:0] MAX_W_C     = CMPW'(MAX_WIDTH);
	localparam logic [CMPW-1:0] ROW_LIMIT_C = CMPW'(bdag_pkg::ROW_LIMIT);
	localparam logic [KW-1:0]   MAX_B_C     = KW'(MAX_BLOCK);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// configuration registers
	logic [KW-1:0]                    block_size_q;
	logic [bdag_pkg::WIDTH_W-1:0]     image_width_q;
	logic [bdag_pkg::HEIGHT_W-1:0]    image_height_q;
	logic                             cfg_wr;
	logic [1:0]                       cfg_idx;

	// clamped configuration
	logic [KW-1:0]   bs_eff;
	logic [CMPW-1:0] w_ext, h_ext, w_eff, h_eff;

	// span unit
	logic            div_start_q, div_busy_q;
	logic [CNTW-1:0] div_cnt_q;
	logic [CMPW-1:0] div_w_q, div_h_q;
	logic [KW-1:0]   rem_w_q, rem_h_q;
	logic [KW:0]     rw_try, rh_try;
	logic [KW-1:0]   rw_next, rh_next;
	logic [CMPW-1:0] span_c_q, span_r_q;

	// stream counters
	logic [CPW-1:0] col_pos_q, blk_col_q;
	logic [RW-1:0]  row_pos_q;
	logic [BW-1:0]  cib_q, rib_q;
	logic [SW-1:0]  rs_q;

	// per-pixel decisions
	logic            in_acc, active, col_end, row_end, row_wrap, frame_wrap;
	logic            last_col, last_row;
	logic [CMPW-1:0] cp_ext, rp_ext;
	logic [SW-1:0]   rs_new;

	// pipeline
	logic [1:0]        state_q;
	logic [SW-1:0]     rs_s1, rd_data_s1;
	logic              first_row_s1, row_end_s1, row_last_s1, frame_last_s1;
	logic [CPW-1:0]    bc_s1;
	logic [SW-1:0]     total;
	logic [SW-1:0]     total_s2;
	logic [31:0]       prod;
	logic [GW-1:0]     mean_s3;
	logic              mem_re, mem_we, out_free;

	// line store of per-block-column partial sums
	logic [SW-1:0] psum_mem [MAX_WIDTH];

	// output register
	logic                          out_valid_q;
	logic [GW-1:0]                 out_mean_q;
	logic [bdag_pkg::GLYPH_W-1:0]  out_glyph_q;
	logic                          out_row_last_q, out_frame_last_q;

	// ------------------------------------------------------------------
	// APB register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= bdag_pkg::BLOCK_SIZE_RST;
			image_width_q  <= bdag_pkg::IMAGE_WIDTH_RST;
			image_height_q <= bdag_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bdag_pkg::REG_BLOCK_SIZE:   block_size_q   <= pwdata[KW-1:0];
				bdag_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[bdag_pkg::WIDTH_W-1:0];
				bdag_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[bdag_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			bdag_pkg::REG_BLOCK_SIZE:   prdata = bdag_pkg::DATA_W'(block_size_q);
			bdag_pkg::REG_IMAGE_WIDTH:  prdata = bdag_pkg::DATA_W'(image_width_q);
			bdag_pkg::REG_IMAGE_HEIGHT: prdata = bdag_pkg::DATA_W'(image_height_q);
			default:                    prdata = '0;
		endcase
	end

	// clamp zero to one and large values to the limits
	assign w_ext  = CMPW'(image_width_q);
	assign h_ext  = CMPW'(image_height_q);
	assign bs_eff = (block_size_q == '0) ? KW'(1) :
		(block_size_q > MAX_B_C) ? MAX_B_C : block_size_q;
	assign w_eff  = (w_ext == '0) ? CMPW'(1) : (w_ext > MAX_W_C) ? MAX_W_C : w_ext;
	assign h_eff  = (h_ext == '0) ? CMPW'(1) : (h_ext > ROW_LIMIT_C) ? ROW_LIMIT_C : h_ext;

	// ------------------------------------------------------------------
	// bit-serial remainder of width and height by block size
	assign rw_try  = {rem_w_q, div_w_q[CMPW-1]};
	assign rh_try  = {rem_h_q, div_h_q[CMPW-1]};
	assign rw_next = (rw_try >= {1'b0, bs_eff}) ? KW'(rw_try - {1'b0, bs_eff}) : KW'(rw_try);
	assign rh_next = (rh_try >= {1'b0, bs_eff}) ? KW'(rh_try - {1'b0, bs_eff}) : KW'(rh_try);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b1;
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
		end else if (cfg_wr) begin
			div_start_q <= 1'b1;
			div_busy_q  <= 1'b0;
		end else if (div_start_q) begin
			div_start_q <= 1'b0;
			div_busy_q  <= 1'b1;
			div_cnt_q   <= CNTW'(CMPW);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - CNTW'(1);
			if (div_cnt_q == CNTW'(1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start_q) begin
			div_w_q <= w_eff;
			div_h_q <= h_eff;
			rem_w_q <= '0;
			rem_h_q <= '0;
		end else if (div_busy_q) begin
			div_w_q <= {div_w_q[CMPW-2:0], 1'b0};
			div_h_q <= {div_h_q[CMPW-2:0], 1'b0};
			rem_w_q <= rw_next;
			rem_h_q <= rh_next;
			if (div_cnt_q == CNTW'(1)) begin
				span_c_q <= w_eff - CMPW'(rw_next);
				span_r_q <= h_eff - CMPW'(rh_next);
			end
		end
	end

	// ------------------------------------------------------------------
	// per-pixel decisions
	assign pixel.ready = (state_q == ST_IDLE) && !div_start_q && !div_busy_q;
	assign in_acc      = pixel.valid && pixel.ready;

	assign cp_ext     = CMPW'(col_pos_q);
	assign rp_ext     = CMPW'(row_pos_q);
	assign active     = (cp_ext < span_c_q) && (rp_ext < span_r_q);
	assign col_end    = KW'(cib_q) >= (bs_eff - KW'(1));
	assign row_end    = KW'(rib_q) >= (bs_eff - KW'(1));
	assign row_wrap   = cp_ext >= (w_eff - CMPW'(1));
	assign frame_wrap = rp_ext >= (h_eff - CMPW'(1));
	assign last_col   = cp_ext == (span_c_q - CMPW'(1));
	assign last_row   = rp_ext == (span_r_q - CMPW'(1));
	assign rs_new     = (cib_q == '0) ? SW'(pixel.grey_level) : rs_q + SW'(pixel.grey_level);

	// advance position counters and the running row sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			blk_col_q <= '0;
			row_pos_q <= '0;
			cib_q     <= '0;
			rib_q     <= '0;
			rs_q      <= '0;
		end else if (in_acc) begin
			if (active) begin
				rs_q <= rs_new;
			end
			if (row_wrap) begin
				col_pos_q <= '0;
				cib_q     <= '0;
				blk_col_q <= '0;
				if (frame_wrap) begin
					row_pos_q <= '0;
					rib_q     <= '0;
				end else begin
					row_pos_q <= row_pos_q + RW'(1);
					rib_q     <= row_end ? '0 : rib_q + BW'(1);
				end
			end else begin
				col_pos_q <= col_pos_q + CPW'(1);
				if (col_end) begin
					cib_q     <= '0;
					blk_col_q <= blk_col_q + CPW'(1);
				end else begin
					cib_q <= cib_q + BW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequencer: read, add and write back, then divide and look up
	assign out_free = !out_valid_q || glyph.ready;
	assign mem_re   = in_acc && active && col_end;
	assign mem_we   = (state_q == ST_SUM) && !row_end_s1;
	assign total    = (first_row_s1 ? '0 : rd_data_s1) + rs_s1;
	assign prod     = 32'(total_s2) * 32'(bdag_pkg::RECIP[4'(bs_eff - KW'(1))]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (mem_re) state_q <= ST_SUM;
				ST_SUM:  state_q <= row_end_s1 ? ST_MUL : ST_IDLE;
				ST_MUL:  state_q <= ST_OUT;
				ST_OUT:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the word's context on a block-column close
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rs_s1         <= rs_new;
			first_row_s1  <= (rib_q == '0);
			row_end_s1    <= row_end;
			bc_s1         <= blk_col_q;
			row_last_s1   <= last_col;
			frame_last_s1 <= last_col && last_row;
		end
		if (state_q == ST_SUM) begin
			total_s2 <= total;
		end
		if (state_q == ST_MUL) begin
			mean_s3 <= prod[bdag_pkg::RECIP_SHIFT +: GW];
		end
	end

	// line store: one read, one write, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			psum_mem[bc_s1] <= total;
		end
		if (mem_re) begin
			rd_data_s1 <= psum_mem[blk_col_q];
		end
	end

	// ------------------------------------------------------------------
	// output register: hold while stalled, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (glyph.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_mean_q       <= mean_s3;
			out_glyph_q      <= bdag_pkg::pick_glyph(mean_s3);
			out_row_last_q   <= row_last_s1;
			out_frame_last_q <= frame_last_s1;
		end
	end

	assign glyph.valid      = out_valid_q;
	assign glyph.mean_grey  = out_mean_q;
	assign glyph.glyph_code = out_glyph_q;
	assign glyph.row_last   = out_row_last_q;
	assign glyph.frame_last = out_frame_last_q;

endmodule

FILE: rtl/bdag_checker.sv
// ----------------------------------------------------------------------------
// bdag_checker
// Port-level checks of the box downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bdag_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pix_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bdag_pkg::GREY_W-1:0]   mean_grey,
	input logic [bdag_pkg::GLYPH_W-1:0]  glyph_code,
	input logic                          row_last,
	input logic                          frame_last,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite
);

	// a stalled word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_grey) && $stable(glyph_code))
		else $error("glyph word changed while stalled");

	// glyph follows the ladder for the shown mean
	a_glyph_ladder: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> glyph_code == bdag_pkg::pick_glyph(mean_grey))
		else $error("glyph code does not match mean grey");

	// the last block of a frame also ends its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> row_last)
		else $error("frame_last without row_last");

	// a register write stops pixel intake while spans are recomputed
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !pix_ready)
		else $error("pixel taken right after a register write");

endmodule

bind box_downscale_ascii_glyph bdag_checker u_bdag_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pixel.ready),
	.out_valid  (glyph.valid),
	.out_ready  (glyph.ready),
	.mean_grey  (glyph.mean_grey),
	.glyph_code (glyph.glyph_code),
	.row_last   (glyph.row_last),
	.frame_last (glyph.frame_last),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite)
);

FILE: test/box_downscale_ascii_glyph_check.sv
// ----------------------------------------------------------------------------
// box_downscale_ascii_glyph_check
// Watches the pixel, glyph and register ports of the box downscaler, keeps
// its own copy of the block sums and raster position, predicts every glyph
// word and compares the words the block gives, field by field, in order.
// ----------------------------------------------------------------------------
module box_downscale_ascii_glyph_check (
	input  logic                        clk,
	input  logic                        arst_n,
	bdag_pix_if                         pixel,
	bdag_glyph_if                       glyph,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bdag_pkg::ADDR_W-1:0] paddr,
	input  logic [bdag_pkg::DATA_W-1:0] pwdata,
	output int                          errors,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [bdag_pkg::GREY_W-1:0]  mean_grey;
		logic [bdag_pkg::GLYPH_W-1:0] glyph_code;
		logic                         row_last;
		logic                         frame_last;
	} glyph_word_t;

	// register copies
	logic [bdag_pkg::BLOCK_W-1:0]  cfg_block;
	logic [bdag_pkg::WIDTH_W-1:0]  cfg_width;
	logic [bdag_pkg::HEIGHT_W-1:0] cfg_height;

	// line store of per-block-column sums and raster position
	logic [bdag_pkg::SUM_W-1:0] col_sums [bdag_pkg::MAX_WIDTH_DEF];
	logic [bdag_pkg::SUM_W-1:0] line_sum;
	int col_pos, row_pos, col_in_blk, row_in_blk, blk_col;

	glyph_word_t expected_glyphs [$];

	// zero acts as one, anything above the top acts as the top
	function automatic int clamp_size(input int v, input int top);
		if (v == 0)
			return 1;
		return (v > top) ? top : v;
	endfunction

	// nine-level threshold ladder, brightest first
	function automatic logic [bdag_pkg::GLYPH_W-1:0] glyph_for(
		input logic [bdag_pkg::GREY_W-1:0] g);
		case (1'b1)
			(g > bdag_pkg::THR_SPACE): return bdag_pkg::GLYPH_SPACE;
			(g > bdag_pkg::THR_DOT):   return bdag_pkg::GLYPH_DOT;
			(g > bdag_pkg::THR_STAR):  return bdag_pkg::GLYPH_STAR;
			(g > bdag_pkg::THR_COLON): return bdag_pkg::GLYPH_COLON;
			(g > bdag_pkg::THR_O):     return bdag_pkg::GLYPH_O;
			(g > bdag_pkg::THR_AMP):   return bdag_pkg::GLYPH_AMP;
			(g > bdag_pkg::THR_EIGHT): return bdag_pkg::GLYPH_EIGHT;
			(g > bdag_pkg::THR_HASH):  return bdag_pkg::GLYPH_HASH;
			default:                   return bdag_pkg::GLYPH_AT;
		endcase
	endfunction

	// take one pixel, return 1 with the word when it closes a whole block
	function automatic bit predict_word(input logic [bdag_pkg::GREY_W-1:0] level,
		output glyph_word_t word);
		int bs, w, h, span_c, span_r, mean_full;
		bit col_end, row_end, hit;
		logic [bdag_pkg::SUM_W-1:0] prev, total;
		bs = clamp_size(cfg_block, bdag_pkg::MAX_BLOCK_DEF);
		w = clamp_size(cfg_width, bdag_pkg::MAX_WIDTH_DEF);
		h = clamp_size(cfg_height, bdag_pkg::ROW_LIMIT);
		span_c = (w / bs) * bs;
		span_r = (h / bs) * bs;
		col_end = (col_in_blk >= bs - 1);
		row_end = (row_in_blk >= bs - 1);
		hit = 1'b0;
		word = '0;

		// accumulate only inside the area of whole blocks
		if (col_pos < span_c && row_pos < span_r) begin
			line_sum = (col_in_blk == 0) ? bdag_pkg::SUM_W'(level) :
				line_sum + bdag_pkg::SUM_W'(level);
			if (col_end && blk_col < bdag_pkg::MAX_WIDTH_DEF) begin
				prev = (row_in_blk == 0) ? '0 : col_sums[blk_col];
				total = prev + line_sum;
				if (row_end) begin
					mean_full = int'(total) / (bs * bs);
					word.mean_grey = bdag_pkg::GREY_W'(mean_full);
					word.glyph_code = glyph_for(word.mean_grey);
					word.row_last = (col_pos == span_c - 1);
					word.frame_last = word.row_last && (row_pos == span_r - 1);
					hit = 1'b1;
				end else begin
					col_sums[blk_col] = total;
				end
			end
		end

		// advance the raster position, wrapping at or beyond the ends
		if (col_pos >= w - 1) begin
			col_pos = 0;
			col_in_blk = 0;
			blk_col = 0;
			if (row_pos >= h - 1) begin
				row_pos = 0;
				row_in_blk = 0;
			end else begin
				row_pos++;
				row_in_blk = row_end ? 0 : row_in_blk + 1;
			end
		end else begin
			col_pos++;
			if (col_end) begin
				col_in_blk = 0;
				blk_col++;
			end else begin
				col_in_blk++;
			end
		end
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		glyph_word_t want, got;
		int miss;
		miss = 0;
		if (!arst_n) begin
			cfg_block = bdag_pkg::BLOCK_SIZE_RST;
			cfg_width = bdag_pkg::IMAGE_WIDTH_RST;
			cfg_height = bdag_pkg::IMAGE_HEIGHT_RST;
			foreach (col_sums[i])
				col_sums[i] = '0;
			line_sum = '0;
			col_pos = 0;
			row_pos = 0;
			col_in_blk = 0;
			row_in_blk = 0;
			blk_col = 0;
			expected_glyphs.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					bdag_pkg::REG_BLOCK_SIZE:   cfg_block = pwdata[bdag_pkg::BLOCK_W-1:0];
					bdag_pkg::REG_IMAGE_WIDTH:  cfg_width = pwdata[bdag_pkg::WIDTH_W-1:0];
					bdag_pkg::REG_IMAGE_HEIGHT: cfg_height = pwdata[bdag_pkg::HEIGHT_W-1:0];
					default: ;
				endcase
			end

			// predict from each accepted pixel word
			if (pixel.valid && pixel.ready) begin
				if (predict_word(pixel.grey_level, want))
					expected_glyphs = {expected_glyphs, want};
			end

			// compare each accepted glyph word with the oldest prediction
			if (glyph.valid && glyph.ready) begin
				got.mean_grey = glyph.mean_grey;
				got.glyph_code = glyph.glyph_code;
				got.row_last = glyph.row_last;
				got.frame_last = glyph.frame_last;
				if (expected_glyphs.size() == 0) begin
					$error("glyph word with no prediction waiting: mean_grey %0d, glyph_code %0d",
						got.mean_grey, got.glyph_code);
					miss++;
				end else begin
					want = expected_glyphs.pop_front();
					if (got.mean_grey !== want.mean_grey) begin
						$error("mean_grey: expected %0d, got %0d", want.mean_grey, got.mean_grey);
						miss++;
					end
					if (got.glyph_code !== want.glyph_code) begin
						$error("glyph_code: expected %0d, got %0d",
							want.glyph_code, got.glyph_code);
						miss++;
					end
					if (got.row_last !== want.row_last) begin
						$error("row_last: expected %0d, got %0d", want.row_last, got.row_last);
						miss++;
					end
					if (got.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d",
							want.frame_last, got.frame_last);
						miss++;
					end
				end
			end
			errors <= errors + miss;
			pending <= expected_glyphs.size();
		end
	end

endmodule

FILE: test/box_downscale_ascii_glyph_tb.sv
// ----------------------------------------------------------------------------
// box_downscale_ascii_glyph_tb
// Drives pixel frames and register settings into the box downscaler under
// varied sender gaps and receiver stalls; the check module predicts and
// compares the glyph words, and this module gives the verdict.
// ----------------------------------------------------------------------------
module box_downscale_ascii_glyph_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int MODE_PIXELS  = 415;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [bdag_pkg::ADDR_W-1:0] paddr;
	logic [bdag_pkg::DATA_W-1:0] pwdata, prdata;

	int gap_pct, stall_pct, pixels_sent, errors, pending, idle_cycles;

	bdag_pix_if   pix_ch ();
	bdag_glyph_if glyph_ch ();

	box_downscale_ascii_glyph DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_ch),
		.glyph   (glyph_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	box_downscale_ascii_glyph_check glyph_monitor (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_ch),
		.glyph   (glyph_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending)
	);

	always #10 clk = ~clk;

	// stall the glyph receiver at random
	always @(posedge clk) begin
		glyph_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (glyph_ch.valid && glyph_ch.ready) ||
			(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one register write: setup cycle, then access cycle
	task automatic apb_write(input logic [1:0] index,
		input logic [bdag_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold pixels until every predicted word is out and the pipe is empty
	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_format(input int bs, input int w, input int h);
		drain_results();
		apb_write(bdag_pkg::REG_BLOCK_SIZE, bs);
		apb_write(bdag_pkg::REG_IMAGE_WIDTH, w);
		apb_write(bdag_pkg::REG_IMAGE_HEIGHT, h);
	endtask

	// offer one pixel word, with a random gap first
	task automatic send_pixel(input logic [bdag_pkg::GREY_W-1:0] level);
		if ($urandom_range(99) < gap_pct) begin
			pix_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.grey_level <= level;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
	endtask

	// style 0: noise, 1: black and white, else a level with small noise
	task automatic send_pixels(input int count, input int style,
		input logic [bdag_pkg::GREY_W-1:0] base);
		logic [bdag_pkg::GREY_W-1:0] level;
		for (int i = 0; i < count; i++) begin
			case (style)
				0:       level = bdag_pkg::GREY_W'($urandom);
				1:       level = $urandom_range(1) ? 8'd255 : 8'd0;
				default: level = base ^ bdag_pkg::GREY_W'($urandom_range(15));
			endcase
			send_pixel(level);
		end
	endtask

	// pull a frame cut short back to the origin: a 1x1 frame wraps both counters
	task automatic realign();
		set_format(1, 1, 1);
		send_pixel(bdag_pkg::GREY_W'($urandom));
	endtask

	// whole frame of random size, mostly small blocks
	task automatic random_frame();
		int bs, w, h, pick;
		pick = $urandom_range(99);
		if (pick < 40)
			bs = 1;
		else if (pick < 70)
			bs = 2;
		else if (pick < 85)
			bs = 3;
		else if (pick < 95)
			bs = 4;
		else
			bs = $urandom_range(5, 8);
		w = $urandom_range(1, bs * 2 + 12);
		h = $urandom_range(1, bs + 4);
		set_format(bs, w, h);
		send_pixels(w * h, $urandom_range(2), bdag_pkg::GREY_W'($urandom));
	endtask

	initial begin
		int mode_start;
		pix_ch.valid <= 1'b0;
		pix_ch.grey_level <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixels_sent = 0;
		gap_pct = 15;
		stall_pct = 61;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// two whole 2x2 blocks at the grey extremes
		set_format(2, 4, 2);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd255);
		send_pixel(8'd254);

		// zero size, width and height act as one
		set_format(0, 0, 0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd128);

		// oversize block acts as 16, larger than the picture: no words
		set_format(31, 3, 2);
		send_pixel(8'd86);
		send_pixel(8'd87);
		send_pixel(8'd114);
		send_pixel(8'd115);
		send_pixel(8'd142);
		send_pixel(8'd143);

		// block size change in mid-frame at a block row boundary
		set_format(1, 2, 4);
		send_pixel(8'd30);
		send_pixel(8'd31);
		send_pixel(8'd58);
		send_pixel(8'd59);
		drain_results();
		apb_write(bdag_pkg::REG_BLOCK_SIZE, 2);
		send_pixel(8'd226);
		send_pixel(8'd227);
		send_pixel(8'd198);
		send_pixel(8'd199);

		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin
					gap_pct = 15;
					stall_pct = 61;
				end
				1: begin
					gap_pct = 61;
					stall_pct = 15;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			mode_start = pixels_sent;

			// size extremes, cut short where a whole frame would be too long
			case (m)
				0: begin
					set_format(0, 1, 1024);
					send_pixels(40, 0, 8'd0);
					realign();
				end
				1: begin
					set_format(1, 2047, 2047);
					send_pixels(60, 0, 8'd0);
					realign();
					set_format(1, 1024, 1);
					send_pixels(30, 2, bdag_pkg::GREY_W'($urandom));
					realign();
				end
				default: begin
					set_format(16, 17, 16);
					send_pixels(17 * 16, 2, bdag_pkg::GREY_W'($urandom));
				end
			endcase

			while (pixels_sent - mode_start < MODE_PIXELS)
				random_frame();
		end

		drain_results();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
